/* rtl/assert_macros.svh */
// Assertion macros used by the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error("same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("next-cycle check failed");

`endif

/* rtl/pehp_pkg.sv */
// Package for the PE header identity parser: request types, status codes, constants.
`default_nettype none

package pehp_pkg;

  // Default upper bound on the header offset
  localparam int unsigned MAX_HEADER_OFFSET_DEF = 1048576;

  // Layout of the image headers
  localparam int unsigned DOS_SIZE     = 64;
  localparam int unsigned OFFSET_FIELD = 60;
  localparam int unsigned PE_SIZE      = 24;
  localparam int unsigned OPT_SIZE     = 64;
  localparam int unsigned MIN_OPT_SIZE = 60;

  localparam logic [15:0] DOS_SIG     = 16'h5a4d;       // "MZ"
  localparam logic [31:0] PE_SIG      = 32'h0000_4550;  // "PE\0\0"
  localparam logic [15:0] PE32P_MAGIC = 16'h020b;

  // Status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_MZ      = 3'd1;
  localparam logic [2:0] ST_OFFSET     = 3'd2;
  localparam logic [2:0] ST_BAD_PE     = 3'd3;
  localparam logic [2:0] ST_OPT_SMALL  = 3'd4;
  localparam logic [2:0] ST_NOT_PE32P  = 3'd5;
  localparam logic [2:0] ST_TRUNCATED  = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] machine_type;
    logic [31:0] link_timestamp;
    logic [15:0] opt_hdr_magic;
    logic [63:0] preferred_base;
    logic [31:0] size_of_image;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/pehp_parser.sv */
// Byte position tracking, header field capture and status decision for one image.
`default_nettype none

module pehp_parser #(
  parameter int unsigned MAX_HEADER_OFFSET = pehp_pkg::MAX_HEADER_OFFSET_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire pehp_pkg::in_item_t item,
  output logic                    res_valid,
  output pehp_pkg::out_item_t     res_data
);

  // Position counter covers the furthest byte that can still yield a result
  localparam int unsigned PW = $clog2(MAX_HEADER_OFFSET + pehp_pkg::PE_SIZE
                                      + pehp_pkg::OPT_SIZE + 1);
  localparam logic [PW-1:0] DOS_END  = PW'(pehp_pkg::DOS_SIZE);
  localparam logic [PW-1:0] OFF_LO   = PW'(pehp_pkg::OFFSET_FIELD);
  localparam logic [PW-1:0] PE_END   = PW'(pehp_pkg::PE_SIZE);
  localparam logic [PW-1:0] HDR_END  = PW'(pehp_pkg::PE_SIZE + pehp_pkg::OPT_SIZE);
  localparam logic [31:0]   MAX_OFF  = 32'(MAX_HEADER_OFFSET);
  localparam logic [31:0]   MIN_OFF  = 32'(pehp_pkg::DOS_SIZE);
  localparam logic [15:0]   MIN_OPT  = 16'(pehp_pkg::MIN_OPT_SIZE);

  logic [PW-1:0] pos_r, pos_nxt;
  logic          given_r, given_nxt;
  logic [15:0]   dos_r, dos_nxt;
  logic [31:0]   off_r, off_nxt;
  logic [31:0]   pesig_r, pesig_nxt;
  logic [15:0]   machine_r, machine_nxt;
  logic [31:0]   stamp_r, stamp_nxt;
  logic [15:0]   optsz_r, optsz_nxt;
  logic [15:0]   magic_r, magic_nxt;
  logic [63:0]   base_r, base_nxt;
  logic [31:0]   size_r, size_nxt;

  logic [PW-1:0] rel;
  logic [4:0]    rel5;
  logic [5:0]    opt;
  logic [2:0]    status;
  logic          fill;
  logic [7:0]    b;

  assign b    = item.data_byte;
  assign rel  = pos_r - off_r[PW-1:0];
  assign rel5 = rel[4:0];
  assign opt  = 6'(rel - PE_END);

  // Decide capture and result for the byte in the input register
  always_comb begin
    pos_nxt     = pos_r;
    given_nxt   = given_r;
    dos_nxt     = dos_r;
    off_nxt     = off_r;
    pesig_nxt   = pesig_r;
    machine_nxt = machine_r;
    stamp_nxt   = stamp_r;
    optsz_nxt   = optsz_r;
    magic_nxt   = magic_r;
    base_nxt    = base_r;
    size_nxt    = size_r;
    res_valid   = 1'b0;
    status      = pehp_pkg::ST_OK;
    fill        = 1'b0;
    if (step) begin
      if (given_r) begin
        // Drop bytes until the image ends
        if (item.last_byte) begin
          pos_nxt   = '0;
          given_nxt = 1'b0;
        end
      end else begin
        if (pos_r < DOS_END) begin
          // DOS header: signature and header offset
          if (pos_r == PW'(0)) begin
            dos_nxt[7:0] = b;
          end else if (pos_r == PW'(1)) begin
            dos_nxt[15:8] = b;
          end else if (pos_r >= OFF_LO) begin
            off_nxt[{pos_r[1:0], 3'b000} +: 8] = b;
          end
          if (pos_r == DOS_END - PW'(1)) begin
            if (dos_nxt != pehp_pkg::DOS_SIG) begin
              res_valid = 1'b1;
              status    = pehp_pkg::ST_NO_MZ;
            end else if (off_nxt < MIN_OFF || off_nxt > MAX_OFF) begin
              res_valid = 1'b1;
              status    = pehp_pkg::ST_OFFSET;
            end
          end
        end else if (pos_r >= off_r[PW-1:0]) begin
          if (rel < PE_END) begin
            // COFF header
            if (rel5 < 5'd4) begin
              pesig_nxt[{rel5[1:0], 3'b000} +: 8] = b;
            end else if (rel5 < 5'd6) begin
              machine_nxt[{rel5[0], 3'b000} +: 8] = b;
            end else if (rel5 >= 5'd8 && rel5 < 5'd12) begin
              stamp_nxt[{rel5[1:0], 3'b000} +: 8] = b;
            end else if (rel5 == 5'd20 || rel5 == 5'd21) begin
              optsz_nxt[{rel5[0], 3'b000} +: 8] = b;
            end
            if (rel == PE_END - PW'(1)) begin
              if (pesig_r != pehp_pkg::PE_SIG) begin
                res_valid = 1'b1;
                status    = pehp_pkg::ST_BAD_PE;
              end else if (optsz_r < MIN_OPT) begin
                res_valid = 1'b1;
                status    = pehp_pkg::ST_OPT_SMALL;
              end
            end
          end else if (rel < HDR_END) begin
            // Optional header
            if (opt < 6'd2) begin
              magic_nxt[{opt[0], 3'b000} +: 8] = b;
            end else if (opt >= 6'd24 && opt < 6'd32) begin
              base_nxt[{opt[2:0], 3'b000} +: 8] = b;
            end else if (opt >= 6'd56 && opt < 6'd60) begin
              size_nxt[{opt[1:0], 3'b000} +: 8] = b;
            end
            if (opt == 6'd63) begin
              res_valid = 1'b1;
              fill      = 1'b1;
              status    = (magic_r == pehp_pkg::PE32P_MAGIC) ? pehp_pkg::ST_OK
                                                             : pehp_pkg::ST_NOT_PE32P;
            end
          end
        end
        // Image ended before any verdict
        if (!res_valid && item.last_byte) begin
          res_valid = 1'b1;
          status    = pehp_pkg::ST_TRUNCATED;
        end
        if (item.last_byte) begin
          pos_nxt   = '0;
          given_nxt = 1'b0;
        end else begin
          pos_nxt   = pos_r + PW'(1);
          given_nxt = res_valid;
        end
      end
    end
  end

  // Build the result; fields stay zero unless the optional header was read in full
  always_comb begin
    res_data                = '0;
    res_data.status         = status;
    if (fill) begin
      res_data.machine_type   = machine_r;
      res_data.link_timestamp = stamp_r;
      res_data.opt_hdr_magic  = magic_r;
      res_data.preferred_base = base_r;
      res_data.size_of_image  = size_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      given_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      given_r <= given_nxt;
    end
  end

  // Captured header fields
  always_ff @(posedge clk) begin
    dos_r     <= dos_nxt;
    off_r     <= off_nxt;
    pesig_r   <= pesig_nxt;
    machine_r <= machine_nxt;
    stamp_r   <= stamp_nxt;
    optsz_r   <= optsz_nxt;
    magic_r   <= magic_nxt;
    base_r    <= base_nxt;
    size_r    <= size_nxt;
  end

endmodule

`default_nettype wire

/* rtl/pe_header_identity_parser.sv */
// PE32+ header identity parser: top level with input and result registers.
//
// Usage: feed the image one byte per request on in_data, in address order from
// offset zero, with last_byte set on the final byte of the image. The block
// gives at most one result per image on out_data: a status code and the
// machine, timestamp, magic, image base and image size fields (zero unless
// the optional header was read in full). The result appears on the byte that
// decides it: byte 63 for DOS header errors, header offset + 23 for COFF
// errors, header offset + 87 for the final verdict, or the last byte when the
// image ends early. Later bytes of that image are dropped without a result.
// Registers: an accepted request is held in the input register, and its result
// is loaded into the result register.
// Throughput: one byte per cycle unless stalled; one pass decides each byte.
// Stall: while out_stall holds a result, the input register keeps one
// request and in_stall rises once it is full.
// Reset: rst_n clears the position count and both valid flags; the next byte
// taken is offset zero of a new image.
`default_nettype none
`include "assert_macros.svh"

module pe_header_identity_parser #(
  parameter int unsigned MAX_HEADER_OFFSET = pehp_pkg::MAX_HEADER_OFFSET_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pehp_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pehp_pkg::out_item_t      out_data
);

  logic                s1_valid_r, s1_valid_nxt;
  pehp_pkg::in_item_t  s1_data_r;
  logic                s1_adv;
  logic                in_take;
  logic                out_valid_r, out_valid_nxt;
  pehp_pkg::out_item_t out_data_r;
  logic                res_valid;
  pehp_pkg::out_item_t res_data;
  logic                early_status;
  logic                fields_zero;

  // Advance the held request when the result register can take its outcome
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  pehp_parser #(
    .MAX_HEADER_OFFSET(MAX_HEADER_OFFSET)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .item      (s1_data_r),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  // Load a new result or drop the delivered one
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (s1_adv && res_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (s1_adv && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Classify the held result for the checks below
  assign early_status = out_data_r.status != pehp_pkg::ST_OK &&
                        out_data_r.status != pehp_pkg::ST_NOT_PE32P;
  assign fields_zero  = out_data_r.machine_type == 16'd0 &&
                        out_data_r.link_timestamp == 32'd0 &&
                        out_data_r.opt_hdr_magic == 16'd0 &&
                        out_data_r.preferred_base == 64'd0 &&
                        out_data_r.size_of_image == 32'd0;

  // Early errors and truncation carry zero fields
  `ASSERT_SAME(a_zero_fields, clk, rst_n, out_valid_r && early_status, fields_zero)
  // A held request that cannot advance keeps its contents
  `ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_data_r))
  // A result produced by an advancing request shows up on the output
  `ASSERT_NEXT(a_res_loaded, clk, rst_n, s1_adv && res_valid, out_valid_r)

endmodule

`default_nettype wire
